>>> rtl/rop_pkg.sv
// Package for the REL object bitstream packer: opcodes, item codes, stream constants
// and the command record passed from the front end to the bit packer.
// No dependencies.
`default_nettype none
package rop_pkg;

   localparam logic [2:0] OP_ABS     = 3'd0;
   localparam logic [2:0] OP_WORD    = 3'd1;
   localparam logic [2:0] OP_SPECIAL = 3'd2;
   localparam logic [2:0] OP_NAME    = 3'd3;
   localparam logic [2:0] OP_FINAL   = 3'd4;
   localparam logic [2:0] OP_START   = 3'd5;

   localparam logic [3:0] CODE_AFIELD_FIRST = 4'd5;
   localparam logic [3:0] CODE_NAME_BOUND   = 4'd8;
   localparam logic [3:0] CODE_KEEP_HIGH    = 4'd4;
   localparam logic [3:0] CODE_END          = 4'd15;

   localparam logic [3:0] STD_LIMIT_SHORT = 4'd6;
   localparam logic [3:0] STD_LIMIT_LONG  = 4'd8;

   localparam logic [7:0] HDR_ABS_BYTE = 8'h21;
   localparam logic [7:0] HDR_TAIL     = 8'hFE;
   localparam logic [7:0] END_ITEM     = 8'h9E;
   localparam logic [7:0] EOF_BYTE     = 8'hFF;
   localparam logic [7:0] NAME_MASK    = 8'h7F;

   localparam logic REG_EXTENDED = 1'b0;
   localparam logic REG_TRUNCATE = 1'b1;

   localparam int CMD_BITS     = 48;
   localparam int MAX_CMD_BITS = 46;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [CMD_BITS-1:0] bits;
      logic [5:0]          nbits;
      logic                pad;
      logic                clr;
      logic                eof;
   } rop_cmd_type;

   typedef struct packed {
      logic        push;
      rop_cmd_type cmd;
   } rop_push_type;

endpackage
`default_nettype wire

>>> rtl/rop_req_if.sv
// Input channel of the REL packer: valid/ready handshake and one item payload.
// No dependencies.
`default_nettype none
interface rop_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [7:0]  data_byte;
   logic [15:0] value;
   logic [1:0]  segment;
   logic [3:0]  item_code;
   logic        is_external;
   logic        has_name;
   logic [7:0]  name_length;

   modport source (output valid, opcode, data_byte, value, segment, item_code,
                   is_external, has_name, name_length, input ready);
   modport sink (input valid, opcode, data_byte, value, segment, item_code,
                 is_external, has_name, name_length, output ready);
endinterface
`default_nettype wire

>>> rtl/rop_rsp_if.sv
// Result channel of the REL packer: valid/ready handshake and one stream byte.
// No dependencies.
`default_nettype none
interface rop_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       end_of_file;

   modport source (output valid, out_byte, last, end_of_file, input ready);
   modport sink (input valid, out_byte, last, end_of_file, output ready);
endinterface
`default_nettype wire

>>> rtl/rop_front.sv
// Front end of the REL packer: accepts items, tracks the name state and encodes
// each item into an MSB-first bit group. Depends on rop_pkg and rop_req_if.
`default_nettype none
module rop_front #(
   parameter int EXT_NAME_LIMIT = 30
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           extended_format,
   input  wire logic           truncate_to_six,
   input  wire logic           queue_full,
   rop_req_if.sink             req,
   output rop_pkg::rop_push_type push
);
   import rop_pkg::*;

   logic [4:0]          names_left_ff, names_left_in;
   logic                keep_high_ff, keep_high_in;
   logic [CMD_BITS-1:0] acc;
   logic [5:0]          n;
   logic                want_push;
   logic                pad, clr, eof;
   logic [4:0]          ext_lim;
   logic [3:0]          std_max, std_lim;
   logic [7:0]          name_char;
   logic                accept;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      ext_lim = (req.name_length > 8'(EXT_NAME_LIMIT)) ? 5'(EXT_NAME_LIMIT)
                                                       : req.name_length[4:0];
      std_max = truncate_to_six ? STD_LIMIT_SHORT : STD_LIMIT_LONG;
      std_lim = (req.name_length > {4'b0, std_max}) ? std_max : req.name_length[3:0];
      name_char = keep_high_ff ? req.data_byte : (req.data_byte & NAME_MASK);
   end

   always_comb begin
      acc           = '0;
      n             = '0;
      want_push     = 1'b0;
      pad           = 1'b0;
      clr           = 1'b0;
      eof           = 1'b0;
      names_left_in = names_left_ff;
      keep_high_in  = keep_high_ff;
      case (req.opcode)
         OP_ABS: begin
            acc       = {39'b0, 1'b0, req.data_byte};
            n         = 6'd9;
            want_push = 1'b1;
         end
         OP_WORD: begin
            want_push = 1'b1;
            if (req.is_external || req.segment == 2'd0) begin
               acc = {30'b0, 1'b0, req.value[7:0], 1'b0, req.value[15:8]};
               n   = 6'd18;
            end else begin
               acc = {29'b0, 1'b1, req.segment, req.value[7:0], req.value[15:8]};
               n   = 6'd19;
               if (extended_format) begin
                  acc = acc << 16;
                  n   = 6'd35;
               end
            end
         end
         OP_SPECIAL: begin
            want_push     = 1'b1;
            acc           = {41'b0, 3'b100, req.item_code};
            n             = 6'd7;
            names_left_in = '0;
            keep_high_in  = 1'b0;
            if (req.item_code >= CODE_AFIELD_FIRST && req.item_code != CODE_END) begin
               acc = {acc[29:0], req.segment, req.value[7:0], req.value[15:8]};
               n   = n + 6'd18;
               if (extended_format) begin
                  acc = acc << 16;
                  n   = n + 6'd16;
               end
            end
            if (req.item_code < CODE_NAME_BOUND && req.has_name) begin
               if (extended_format) begin
                  acc           = {acc[42:0], ext_lim};
                  n             = n + 6'd5;
                  names_left_in = ext_lim;
               end else begin
                  acc           = {acc[44:0], std_lim[2:0]};
                  n             = n + 6'd3;
                  names_left_in = {1'b0, std_lim};
               end
               keep_high_in = (req.item_code == CODE_KEEP_HIGH);
            end
         end
         OP_NAME: begin
            if (names_left_ff != '0) begin
               acc           = {40'b0, name_char};
               n             = 6'd8;
               want_push     = 1'b1;
               names_left_in = names_left_ff - 5'd1;
            end
         end
         OP_FINAL: begin
            acc           = {32'b0, END_ITEM, EOF_BYTE};
            n             = 6'd16;
            pad           = 1'b1;
            eof           = 1'b1;
            want_push     = 1'b1;
            names_left_in = '0;
            keep_high_in  = 1'b0;
         end
         OP_START: begin
            clr           = 1'b1;
            want_push     = 1'b1;
            names_left_in = '0;
            keep_high_in  = 1'b0;
            if (extended_format) begin
               acc = {30'b0, 1'b1, 1'b0, HDR_ABS_BYTE, HDR_TAIL};
               n   = 6'd18;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      push.push      = accept && want_push;
      push.cmd.bits  = acc << (6'(CMD_BITS) - n);
      push.cmd.nbits = n;
      push.cmd.pad   = pad;
      push.cmd.clr   = clr;
      push.cmd.eof   = eof;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         names_left_ff <= '0;
         keep_high_ff  <= 1'b0;
      end else if (accept) begin
         names_left_ff <= names_left_in;
         keep_high_ff  <= keep_high_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/rop_queue.sv
// Command queue between the REL packer front end and the bit packer.
// Depends on rop_pkg.
`default_nettype none
module rop_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rop_pkg::rop_push_type push,
   input  wire logic                 pop,
   output rop_pkg::rop_cmd_type      head,
   output logic                      full,
   output logic                      empty
);
   import rop_pkg::*;

   rop_cmd_type         slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW:0]   wr_ptr_ff, rd_ptr_ff;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[QUEUE_AW] != rd_ptr_ff[QUEUE_AW]) &&
                  (wr_ptr_ff[QUEUE_AW-1:0] == rd_ptr_ff[QUEUE_AW-1:0]);
   assign head  = slots_ff[rd_ptr_ff[QUEUE_AW-1:0]];

   always_ff @(posedge clock) begin
      if (push.push) begin
         slots_ff[wr_ptr_ff[QUEUE_AW-1:0]] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push.push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.push |-> !full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

>>> rtl/rop_back.sv
// Bit packer of the REL packer: merges queued bit groups into the held partial byte
// and emits one completed byte per cycle through an output register while rsp is not stalled.
// Depends on rop_pkg and rop_rsp_if.
`default_nettype none
module rop_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rop_pkg::rop_cmd_type head,
   input  wire logic                empty,
   output logic                     pop,
   rop_rsp_if.source                rsp
);
   import rop_pkg::*;

   logic                busy_ff, busy_in;
   logic [CMD_BITS-1:0] rem_ff, rem_in;
   logic [5:0]          rem_cnt_ff, rem_cnt_in;
   logic                pad_ff, pad_in;
   logic                clr_ff, clr_in;
   logic                eof_ff, eof_in;
   logic [6:0]          held_ff, held_in;
   logic [2:0]          hcnt_ff, hcnt_in;

   logic                ov_ff, ov_in;
   logic [7:0]          obyte_ff, obyte_in;
   logic                olast_ff, olast_in;
   logic                oeof_ff, oeof_in;

   logic [6:0]          eff_held;
   logic [2:0]          eff_h;
   logic                out_free;
   logic [6:0]          total;
   logic [3:0]          take;
   logic [CMD_BITS-1:0] rem_shift;
   logic [5:0]          cnt_new;
   logic                done;

   function automatic logic [6:0] absorb(input logic [6:0] held, input logic [6:0] top,
                                         input logic [2:0] r);
      logic [13:0] tmp;
      tmp = {held, top} >> (3'd7 - r);
      return tmp[6:0];
   endfunction

   assign rsp.valid       = ov_ff;
   assign rsp.out_byte    = obyte_ff;
   assign rsp.last        = olast_ff;
   assign rsp.end_of_file = oeof_ff;

   always_comb begin
      eff_held  = clr_ff ? 7'd0 : held_ff;
      eff_h     = clr_ff ? 3'd0 : hcnt_ff;
      out_free  = !ov_ff || rsp.ready;
      total     = {4'b0, eff_h} + {1'b0, rem_cnt_ff};
      take      = 4'd8 - {1'b0, eff_h};
      rem_shift = rem_ff << take;
      cnt_new   = rem_cnt_ff - {2'b0, take};

      busy_in    = busy_ff;
      rem_in     = rem_ff;
      rem_cnt_in = rem_cnt_ff;
      pad_in     = pad_ff;
      clr_in     = clr_ff;
      eof_in     = eof_ff;
      held_in    = held_ff;
      hcnt_in    = hcnt_ff;
      done       = 1'b0;

      ov_in    = ov_ff && !rsp.ready;
      obyte_in = obyte_ff;
      olast_in = olast_ff;
      oeof_in  = oeof_ff;

      if (busy_ff) begin
         if (pad_ff && eff_h != 3'd0) begin
            if (out_free) begin
               ov_in    = 1'b1;
               obyte_in = 8'({8'b0, eff_held} << take);
               olast_in = 1'b0;
               oeof_in  = 1'b0;
               held_in  = '0;
               hcnt_in  = '0;
               pad_in   = 1'b0;
               clr_in   = 1'b0;
            end
         end else if (total >= 7'd8) begin
            if (out_free) begin
               ov_in    = 1'b1;
               obyte_in = 8'(({8'b0, eff_held} << take) | 15'(rem_ff[47:40] >> eff_h));
               pad_in   = 1'b0;
               clr_in   = 1'b0;
               oeof_in  = 1'b0;
               if (cnt_new < 6'd8) begin
                  olast_in = 1'b1;
                  oeof_in  = eof_ff;
                  held_in  = absorb(7'd0, rem_shift[47:41], cnt_new[2:0]);
                  hcnt_in  = cnt_new[2:0];
                  done     = 1'b1;
               end else begin
                  olast_in   = 1'b0;
                  rem_in     = rem_shift;
                  rem_cnt_in = cnt_new;
                  held_in    = '0;
                  hcnt_in    = '0;
               end
            end
         end else begin
            held_in = absorb(eff_held, rem_ff[47:41], rem_cnt_ff[2:0]);
            hcnt_in = total[2:0];
            clr_in  = 1'b0;
            pad_in  = 1'b0;
            done    = 1'b1;
         end
      end

      if (done) begin
         busy_in = 1'b0;
      end
      pop = !empty && (!busy_ff || done);
      if (pop) begin
         busy_in    = 1'b1;
         rem_in     = head.bits;
         rem_cnt_in = head.nbits;
         pad_in     = head.pad;
         clr_in     = head.clr;
         eof_in     = head.eof;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ov_ff   <= 1'b0;
         held_ff <= '0;
         hcnt_ff <= '0;
         pad_ff  <= 1'b0;
         clr_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ov_ff   <= ov_in;
         held_ff <= held_in;
         hcnt_ff <= hcnt_in;
         pad_ff  <= pad_in;
         clr_ff  <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      rem_cnt_ff <= rem_cnt_in;
      eof_ff     <= eof_in;
      obyte_ff   <= obyte_in;
      olast_ff   <= olast_in;
      oeof_ff    <= oeof_in;
   end

`ifndef SYNTHESIS
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_cnt_ff <= 6'(MAX_CMD_BITS)) else $error("bit group overrun");
   a_eof_byte: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && oeof_ff) |-> (obyte_ff == EOF_BYTE && olast_ff))
      else $error("terminator byte malformed");
   a_pad_clean: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !pad_ff && !clr_ff && $past(pad_ff && busy_ff && out_free))
      |-> hcnt_ff == 3'd0 || !$past(busy_ff && pad_ff && hcnt_ff != 3'd0))
      else $error("padding left held bits");
`endif

endmodule
`default_nettype wire

>>> rtl/rel_object_bitstream_packer.sv
// REL object bitstream packer, top level: register port, front end, command queue
// and bit packer. Depends on rop_pkg, rop_req_if, rop_rsp_if, rop_front, rop_queue,
// rop_back.
//
// Usage: items enter on req_chan (valid/ready); every completed stream byte leaves on
// rsp_chan with last set on the final byte an item causes and end_of_file on the
// 0xFF terminator that finalize writes. Items that cause no byte (ignored name
// characters, unused opcodes) give nothing on rsp_chan.
// Path: an accepted item is written into a four-entry queue, popped into the bit
// packer's group registers when it is free, and its bytes leave through the output register.
// The bit packer emits one byte per cycle while rsp_chan takes them. The front end
// keeps accepting while the queue has room.
// Reset clears the held partial byte, the name state, the queue and the registers
// (standard format, eight-character names).
// When rsp_chan stalls the output register holds its byte, the packer waits, the
// queue fills and req_chan.ready drops once it is full.
// Registers: byte address 0 extended_format, 4 truncate_to_six; bit 0 of each.
`default_nettype none
module rel_object_bitstream_packer #(
   parameter int EXT_NAME_LIMIT = 30
) (
   input  wire logic        clock,
   input  wire logic        reset,
   rop_req_if.sink          req_chan,
   rop_rsp_if.source        rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import rop_pkg::*;

   logic         extended_ff;
   logic         truncate_ff;
   logic         csr_write;
   rop_push_type push;
   rop_cmd_type  head;
   logic         full, empty, pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         extended_ff <= 1'b0;
         truncate_ff <= 1'b0;
      end else if (csr_write) begin
         case (paddr[2])
            REG_EXTENDED: extended_ff <= pwdata[0];
            REG_TRUNCATE: truncate_ff <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_EXTENDED: prdata = {31'b0, extended_ff};
         REG_TRUNCATE: prdata = {31'b0, truncate_ff};
         default:      prdata = '0;
      endcase
   end

   rop_front #(
      .EXT_NAME_LIMIT(EXT_NAME_LIMIT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .extended_format(extended_ff),
      .truncate_to_six(truncate_ff),
      .queue_full     (full),
      .req            (req_chan),
      .push           (push)
   );

   rop_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .pop  (pop),
      .head (head),
      .full (full),
      .empty(empty)
   );

   rop_back u_back (
      .clock(clock),
      .reset(reset),
      .head (head),
      .empty(empty),
      .pop  (pop),
      .rsp  (rsp_chan)
   );

endmodule
`default_nettype wire

>>> dv/tb_rel_object_bitstream_packer.sv
`timescale 1ns / 1ps
// Testbench for rel_object_bitstream_packer: directed and random item traffic under
// both name formats, checked byte by byte against a bit-level predictor of the stream.
// Depends on rop_pkg, rop_req_if, rop_rsp_if and the packer RTL.
module tb_rel_object_bitstream_packer;
   import rop_pkg::*;

   localparam int         NAME_LIMIT_EXT  = 30;
   localparam int         SETTLE_CYCLES   = 20;
   localparam int         WATCHDOG_LIMIT  = 2000;
   localparam logic [2:0] OP_UNUSED_LO    = 3'd6;
   localparam logic [2:0] SPECIAL_PREFIX  = 3'b100;
   localparam logic [1:0] SEG_ABSOLUTE    = 2'd0;

   typedef struct {
      logic [2:0]  opcode;
      logic [7:0]  data_byte;
      logic [15:0] value;
      logic [1:0]  segment;
      logic [3:0]  item_code;
      logic        is_external;
      logic        has_name;
      logic [7:0]  name_length;
   } rel_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       end_of_file;
   } stream_byte_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   rop_req_if req_if ();
   rop_rsp_if rsp_if ();

   rel_object_bitstream_packer #(.EXT_NAME_LIMIT(NAME_LIMIT_EXT)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predictor state and configuration copy
   logic [6:0] partial_byte;
   logic [2:0] partial_count;
   logic [4:0] pending_name_chars;
   logic       name_keeps_bit7;
   logic       fmt_extended;
   logic       fmt_short_names;

   stream_byte_type item_bytes[$];
   stream_byte_type expected_bytes[$];

   int mismatch_count;
   int counted_items;
   int burst_left;
   bit gaps_on;
   bit stalls_on;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_bit(input logic b);
      logic [7:0] acc;
      acc = {partial_byte, b};
      if (partial_count == 3'd7) begin
         item_bytes.push_back('{out_byte: acc, last: 1'b0, end_of_file: 1'b0});
         partial_byte  = '0;
         partial_count = '0;
      end else begin
         partial_byte  = acc[6:0];
         partial_count = partial_count + 3'd1;
      end
   endfunction

   function automatic void push_bits(input logic [31:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) push_bit(v[i]);
   endfunction

   function automatic void push_abs(input logic [7:0] b);
      push_bit(1'b0);
      push_bits(b, 8);
   endfunction

   function automatic void push_value(input logic [15:0] v);
      push_bits(v[7:0], 8);
      push_bits(v[15:8], 8);
      if (fmt_extended) push_bits(32'd0, 16);
   endfunction

   function automatic void pad_to_byte();
      while (partial_count != 0) push_bit(1'b0);
   endfunction

   // returns 0 when the item is ignored by the packer
   function automatic bit predict_stream_bytes(input rel_item_type it);
      logic [7:0]      limit;
      bit              handled;
      stream_byte_type b;
      handled = 1'b1;
      item_bytes.delete();
      case (it.opcode)
         OP_ABS: push_abs(it.data_byte);
         OP_WORD: begin
            if (it.is_external || it.segment == SEG_ABSOLUTE) begin
               push_abs(it.value[7:0]);
               push_abs(it.value[15:8]);
            end else begin
               push_bit(1'b1);
               push_bits(it.segment, 2);
               push_value(it.value);
            end
         end
         OP_SPECIAL: begin
            push_bits(SPECIAL_PREFIX, 3);
            push_bits(it.item_code, 4);
            pending_name_chars = '0;
            name_keeps_bit7    = 1'b0;
            if (it.item_code >= CODE_AFIELD_FIRST && it.item_code != CODE_END) begin
               push_bits(it.segment, 2);
               push_value(it.value);
            end
            if (it.item_code < CODE_NAME_BOUND && it.has_name) begin
               if (fmt_extended) begin
                  limit = (it.name_length > NAME_LIMIT_EXT) ? 8'(NAME_LIMIT_EXT)
                                                            : it.name_length;
                  push_bits(limit[4:0], 5);
               end else begin
                  limit = fmt_short_names ? 8'(STD_LIMIT_SHORT) : 8'(STD_LIMIT_LONG);
                  if (it.name_length < limit) limit = it.name_length;
                  push_bits(limit[2:0], 3);
               end
               pending_name_chars = limit[4:0];
               name_keeps_bit7    = (it.item_code == CODE_KEEP_HIGH);
            end
         end
         OP_NAME: begin
            if (pending_name_chars != 0) begin
               push_bits(name_keeps_bit7 ? it.data_byte : (it.data_byte & NAME_MASK), 8);
               pending_name_chars = pending_name_chars - 5'd1;
            end else begin
               handled = 1'b0;
            end
         end
         OP_FINAL: begin
            pad_to_byte();
            push_bits(SPECIAL_PREFIX, 3);
            push_bits(CODE_END, 4);
            pad_to_byte();
            item_bytes.push_back('{out_byte: EOF_BYTE, last: 1'b0, end_of_file: 1'b1});
            pending_name_chars = '0;
            name_keeps_bit7    = 1'b0;
         end
         OP_START: begin
            partial_byte       = '0;
            partial_count      = '0;
            pending_name_chars = '0;
            name_keeps_bit7    = 1'b0;
            if (fmt_extended) begin
               push_bit(1'b1);
               push_abs(HDR_ABS_BYTE);
               push_bits(HDR_TAIL, 8);
            end
         end
         default: handled = 1'b0;
      endcase
      foreach (item_bytes[k]) begin
         b      = item_bytes[k];
         b.last = (k == item_bytes.size() - 1);
         expected_bytes.push_back(b);
      end
      return handled;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic rel_item_type make_item(input logic [2:0] op, input logic [7:0] data,
                                              input logic [15:0] value,
                                              input logic [1:0] seg,
                                              input logic [3:0] code, input logic ext,
                                              input logic named, input logic [7:0] nlen);
      rel_item_type it;
      it.opcode      = op;
      it.data_byte   = data;
      it.value       = value;
      it.segment     = seg;
      it.item_code   = code;
      it.is_external = ext;
      it.has_name    = named;
      it.name_length = nlen;
      return it;
   endfunction

   function automatic rel_item_type random_item(input logic [2:0] op);
      return make_item(op, 8'($urandom), 16'($urandom), 2'($urandom), 4'($urandom),
                       ($urandom_range(0, 3) == 0), 1'($urandom),
                       ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 35)));
   endfunction

   task automatic send_item(input rel_item_type it);
      if (gaps_on && burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = $urandom_range(1, 10);
      end
      if (burst_left > 0) burst_left--;
      req_if.valid       <= 1'b1;
      req_if.opcode      <= it.opcode;
      req_if.data_byte   <= it.data_byte;
      req_if.value       <= it.value;
      req_if.segment     <= it.segment;
      req_if.item_code   <= it.item_code;
      req_if.is_external <= it.is_external;
      req_if.has_name    <= it.has_name;
      req_if.name_length <= it.name_length;
      do @(posedge clock); while (!req_if.ready);
      if (predict_stream_bytes(it)) counted_items++;
   endtask

   // hold the sender until every expected byte has come out
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic val);
      logic [31:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {31'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (readback[0] !== val)
         report_mismatch($sformatf("register %0d reads %0d, wrote %0d", idx, readback[0], val));
   endtask

   task automatic set_format(input logic ext, input logic short_names);
      wait_idle();
      csr_write(REG_EXTENDED, ext);
      csr_write(REG_TRUNCATE, short_names);
      fmt_extended    = ext;
      fmt_short_names = short_names;
   endtask

   task automatic test_standard_encoding();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      set_format(1'b0, 1'b0);
      send_item(make_item(OP_START, 8'h00, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_ABS, 8'h00, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_ABS, 8'hFF, 16'hFFFF, 2'd3, 4'd15, 1'b1, 1'b1, 8'hFF));
      send_item(make_item(OP_WORD, 8'h00, 16'h1234, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_WORD, 8'h00, 16'hFFFF, 2'd3, 4'd0, 1'b1, 1'b0, 8'd0));
      send_item(make_item(OP_WORD, 8'h00, 16'h0000, 2'd1, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_WORD, 8'h00, 16'hFFFF, 2'd3, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_SPECIAL, 8'h00, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_SPECIAL, 8'h00, 16'h0000, 2'd0, CODE_KEEP_HIGH, 1'b0, 1'b1,
                          8'd255));
      send_item(make_item(OP_NAME, 8'hFF, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_NAME, 8'h80, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
      // replaces the remaining keep-high name
      send_item(make_item(OP_SPECIAL, 8'h00, 16'h0000, 2'd0, 4'd7, 1'b0, 1'b1, 8'd2));
      send_item(make_item(OP_NAME, 8'hFF, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_NAME, 8'hFF, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_NAME, 8'h55, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_SPECIAL, 8'h00, 16'hFFFF, 2'd3, CODE_AFIELD_FIRST, 1'b0, 1'b1,
                          8'd0));
      send_item(make_item(OP_SPECIAL, 8'h00, 16'h0000, 2'd2, 4'd14, 1'b0, 1'b1, 8'd4));
      send_item(make_item(OP_SPECIAL, 8'h00, 16'h0000, 2'd0, CODE_END, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_UNUSED_LO, 8'hFF, 16'hFFFF, 2'd3, 4'd15, 1'b1, 1'b1, 8'hFF));
      send_item(make_item(OP_UNUSED_LO + 3'd1, 8'h00, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0,
                          8'd0));
      send_item(make_item(OP_FINAL, 8'h00, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
   endtask

   task automatic test_extended_encoding();
      set_format(1'b1, 1'b1);
      send_item(make_item(OP_START, 8'h00, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_SPECIAL, 8'h00, 16'h0000, 2'd0, 4'd3, 1'b0, 1'b1, 8'd31));
      send_item(make_item(OP_NAME, 8'hFF, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_ABS, 8'h7E, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_NAME, 8'h00, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_WORD, 8'h00, 16'hFFFF, 2'd2, 4'd0, 1'b0, 1'b0, 8'd0));
      send_item(make_item(OP_SPECIAL, 8'h00, 16'h8001, 2'd1, 4'd6, 1'b0, 1'b1, 8'd5));
      send_item(make_item(OP_FINAL, 8'h00, 16'h0000, 2'd0, 4'd0, 1'b0, 1'b0, 8'd0));
   endtask

   task automatic test_random_traffic(input logic ext, input logic short_names,
                                      input int item_target, input bit gaps,
                                      input bit stalls);
      int           stop_at;
      int           half_at;
      bit           paused;
      int           pick;
      rel_item_type it;
      set_format(ext, short_names);
      gaps_on   = gaps;
      stalls_on = stalls;
      stop_at   = counted_items + item_target;
      half_at   = counted_items + item_target / 2;
      paused    = 1'b0;
      while (counted_items < stop_at) begin
         if (!paused && counted_items >= half_at) begin
            wait_idle();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            it           = random_item(OP_SPECIAL);
            it.item_code = 4'($urandom_range(0, 7));
            it.has_name  = 1'b1;
            send_item(it);
            while (pending_name_chars != 0 && $urandom_range(0, 19) != 0) begin
               if ($urandom_range(0, 7) == 0)
                  send_item(random_item($urandom_range(0, 1) ? OP_WORD : OP_ABS));
               send_item(random_item(OP_NAME));
            end
            if ($urandom_range(0, 4) == 0) send_item(random_item(OP_NAME));
         end else if (pick < 60) begin
            send_item(random_item(OP_WORD));
         end else if (pick < 72) begin
            send_item(random_item(OP_ABS));
         end else if (pick < 84) begin
            send_item(random_item(OP_SPECIAL));
         end else if (pick < 88) begin
            send_item(random_item(OP_NAME));
         end else if (pick < 92) begin
            send_item(random_item(OP_FINAL));
         end else if (pick < 95) begin
            send_item(random_item(OP_START));
         end else begin
            send_item(random_item(OP_UNUSED_LO + 3'($urandom_range(0, 1))));
         end
      end
   endtask

   // receiver stall pattern, a 16-bit ready mask redrawn each time pattern_age wraps
   initial begin
      logic [15:0] ready_pattern;
      int          pattern_age;
      ready_pattern = 16'hFFFF;
      pattern_age   = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (pattern_age == 64) begin
            pattern_age = 0;
            case ($urandom_range(0, 3))
               0:       ready_pattern = 16'hFFFF;
               1:       ready_pattern = 16'($urandom) & 16'($urandom);
               default: ready_pattern = 16'($urandom) | 16'($urandom);
            endcase
            if (ready_pattern == 16'h0000) ready_pattern = 16'h0001;
         end
         rsp_if.ready <= stalls_on ? ready_pattern[pattern_age % 16] : 1'b1;
         pattern_age++;
      end
   end

   always @(posedge clock) begin
      stream_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_if.out_byte));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_if.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, want %02h",
                                         rsp_if.out_byte, want.out_byte));
            if (rsp_if.last !== want.last)
               report_mismatch($sformatf("last %0d, want %0d on byte %02h",
                                         rsp_if.last, want.last, want.out_byte));
            if (rsp_if.end_of_file !== want.end_of_file)
               report_mismatch($sformatf("end_of_file %0d, want %0d on byte %02h",
                                         rsp_if.end_of_file, want.end_of_file,
                                         want.out_byte));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("[rel_object_bitstream_packer] ERROR");
         $finish;
      end
   end

   initial begin
      partial_byte       = '0;
      partial_count      = '0;
      pending_name_chars = '0;
      name_keeps_bit7    = 1'b0;
      fmt_extended       = 1'b0;
      fmt_short_names    = 1'b0;
      mismatch_count     = 0;
      counted_items      = 0;
      burst_left         = 0;
      gaps_on            = 1'b0;
      stalls_on          = 1'b0;
      idle_cycles        = 0;
      reset              <= 1'b1;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      req_if.valid       <= 1'b0;
      req_if.opcode      <= OP_ABS;
      req_if.data_byte   <= '0;
      req_if.value       <= '0;
      req_if.segment     <= '0;
      req_if.item_code   <= '0;
      req_if.is_external <= 1'b0;
      req_if.has_name    <= 1'b0;
      req_if.name_length <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_standard_encoding();
      test_extended_encoding();
      test_random_traffic(1'b0, 1'b0, 110, 1'b0, 1'b0);
      test_random_traffic(1'b1, 1'b0, 120, 1'b1, 1'b1);
      test_random_traffic(1'b0, 1'b1, 115, 1'b1, 1'b1);
      test_random_traffic(1'b1, 1'b1, 115, 1'b1, 1'b0);
      wait_idle();

      if (mismatch_count == 0)
         $display("[rel_object_bitstream_packer] OK");
      else
         $display("[rel_object_bitstream_packer] ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/rop_pkg.sv
rtl/rop_req_if.sv
rtl/rop_rsp_if.sv
rtl/rop_front.sv
rtl/rop_queue.sv
rtl/rop_back.sv
rtl/rel_object_bitstream_packer.sv
dv/tb_rel_object_bitstream_packer.sv
